FILE: design/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types and codes for the sorted set table.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned FieldW = 8;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_LOOKUP = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NOCHANGE = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_UPD  = 1'b1
  } state_e;

  typedef struct packed {
    logic [1:0]               kind;
    logic signed [ValueW-1:0] value;
  } req_t;

  typedef struct packed {
    logic              found;
    logic [FieldW-1:0] position;
    logic [FieldW-1:0] count;
    logic [1:0]        status;
  } rsp_t;

  // per-cycle controls shared by every cell of the row
  typedef struct packed {
    logic cmp_en;
    logic ins;
    logic rem;
  } cell_ctl_t;

endpackage

FILE: design/sst_cell.sv
// ----------------------------------------------------------------------------
// sst_cell
// One entry of the sorted row: compares against the request key and
// shifts toward or away from its neighbors on insert and remove.
// ----------------------------------------------------------------------------
module sst_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sst_pkg::cell_ctl_t                ctl_i,
  input  logic signed [sst_pkg::ValueW-1:0] key_i,
  input  logic [CW-1:0]                     count_i,
  input  logic signed [sst_pkg::ValueW-1:0] prev_val_i,
  input  logic                              prev_lt_i,
  input  logic signed [sst_pkg::ValueW-1:0] next_val_i,
  output logic signed [sst_pkg::ValueW-1:0] val_o,
  output logic                              lt_o,
  output logic                              eq_o
);

  logic signed [sst_pkg::ValueW-1:0] val_d, val_q;
  logic                              lt_d, lt_q, eq_d, eq_q;
  logic                              occupied;

  assign occupied = CW'(IDX) < count_i;

  always_comb begin
    lt_d  = lt_q;
    eq_d  = eq_q;
    val_d = val_q;
    if (ctl_i.cmp_en) begin
      lt_d = occupied && (val_q < key_i);
      eq_d = occupied && (val_q == key_i);
    end
    // entries below the lower bound stay put
    if (ctl_i.ins && !lt_q) begin
      val_d = prev_lt_i ? key_i : prev_val_i;
    end else if (ctl_i.rem && !lt_q) begin
      val_d = next_val_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      eq_q <= 1'b0;
    end else begin
      lt_q <= lt_d;
      eq_q <= eq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;
  assign lt_o  = lt_q;
  assign eq_o  = eq_q;

endmodule

FILE: design/sst_enc.sv
// ----------------------------------------------------------------------------
// sst_enc
// Turns the row's less-than thermometer into the lower-bound index and
// folds the per-cell matches into one hit flag.
// ----------------------------------------------------------------------------
module sst_enc #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned CW    = 8
) (
  input  logic [DEPTH-1:0] lt_i,
  input  logic [DEPTH-1:0] eq_i,
  output logic [CW-1:0]    pos_o,
  output logic             found_o
);

  logic [DEPTH:0] edge_oh;

  always_comb begin
    edge_oh[0]     = !lt_i[0];
    for (int i = 1; i < DEPTH; i++) begin
      edge_oh[i] = lt_i[i-1] && !lt_i[i];
    end
    edge_oh[DEPTH] = lt_i[DEPTH-1];
  end

  // one-hot to binary, each index bit an or over its positions
  always_comb begin
    pos_o = '0;
    for (int i = 0; i <= DEPTH; i++) begin
      pos_o = pos_o | (edge_oh[i] ? CW'(i) : '0);
    end
  end

  assign found_o = |eq_i;

endmodule

FILE: design/sorted_set_table.sv
// A request is compared against the row as it transfers; its result is registered
// when the row shifts in the update state. No new request is taken until then, and a
// stalled result holds the row in the update state, which delays the shift.
// Reset: the entry count clears to zero, handshakes go idle; entry contents
// are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
// sorted_set_table
// Ascending set of distinct signed values held in a row of shifting cells,
// serving insert, remove and lookup requests.
// ----------------------------------------------------------------------------
module sorted_set_table #(
  parameter int unsigned DEPTH = 128
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sst_pkg::req_t in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output sst_pkg::rsp_t out_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  sst_pkg::state_e    state_d, state_q;
  sst_pkg::req_t      req_q;
  sst_pkg::rsp_t      rsp_d, rsp_q;
  sst_pkg::cell_ctl_t ctl;
  logic [CW-1:0]      count_d, count_q;
  logic               out_valid_d, out_valid_q;
  logic               in_xfer, upd_go, full, found;
  logic [CW-1:0]      pos;
  logic signed [sst_pkg::ValueW-1:0] key;

  logic signed [sst_pkg::ValueW-1:0] cell_val [DEPTH];
  logic [DEPTH-1:0]                  cell_lt, cell_eq;

  assign in_ready_o = (state_q == sst_pkg::S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign upd_go     = (state_q == sst_pkg::S_UPD) && (!out_valid_q || out_ready_i);
  assign full       = (count_q == CW'(DEPTH));
  assign key        = in_ready_o ? in_i.value : req_q.value;

  sst_enc #(
    .DEPTH(DEPTH),
    .CW   (CW)
  ) u_enc (
    .lt_i   (cell_lt),
    .eq_i   (cell_eq),
    .pos_o  (pos),
    .found_o(found)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    rsp_d       = rsp_q;
    ctl         = '0;
    ctl.cmp_en  = in_xfer;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      sst_pkg::S_IDLE: begin
        if (in_xfer) begin
          state_d = sst_pkg::S_UPD;
        end
      end
      sst_pkg::S_UPD: begin
        if (upd_go) begin
          rsp_d.found    = found;
          rsp_d.position = sst_pkg::FieldW'(pos);
          case (req_q.kind)
            sst_pkg::KIND_INSERT: begin
              if (found) begin
                rsp_d.status = sst_pkg::ST_NOCHANGE;
              end else if (full) begin
                rsp_d.status = sst_pkg::ST_FULL;
              end else begin
                rsp_d.status = sst_pkg::ST_DONE;
                ctl.ins      = 1'b1;
                count_d      = count_q + CW'(1);
              end
            end
            sst_pkg::KIND_REMOVE: begin
              if (found) begin
                rsp_d.status = sst_pkg::ST_DONE;
                ctl.rem      = 1'b1;
                count_d      = count_q - CW'(1);
              end else begin
                rsp_d.status = sst_pkg::ST_NOCHANGE;
              end
            end
            default: begin
              rsp_d.status = found ? sst_pkg::ST_DONE : sst_pkg::ST_NOCHANGE;
            end
          endcase
          rsp_d.count = sst_pkg::FieldW'(count_d);
          out_valid_d = 1'b1;
          state_d     = sst_pkg::S_IDLE;
        end
      end
      default: state_d = sst_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sst_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q <= in_i;
    end
    rsp_q <= rsp_d;
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [sst_pkg::ValueW-1:0] prev_val, next_val;
    logic                              prev_lt;

    if (g == 0) begin : g_first
      assign prev_val = cell_val[g];
      assign prev_lt  = 1'b1;
    end else begin : g_mid
      assign prev_val = cell_val[g-1];
      assign prev_lt  = cell_lt[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign next_val = cell_val[g];
    end else begin : g_body
      assign next_val = cell_val[g+1];
    end

    sst_cell #(
      .IDX(g),
      .CW (CW)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .key_i     (key),
      .count_i   (count_q),
      .prev_val_i(prev_val),
      .prev_lt_i (prev_lt),
      .next_val_i(next_val),
      .val_o     (cell_val[g]),
      .lt_o      (cell_lt[g]),
      .eq_o      (cell_eq[g])
    );
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = rsp_q;

endmodule

FILE: design/sst_check.sv
// ----------------------------------------------------------------------------
// sst_check
// Port-level checks for the sorted set table, bound to the top level.
// ----------------------------------------------------------------------------
module sst_check (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input sst_pkg::rsp_t out_o
);

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while previous one still in the row");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result changed or dropped");

  a_full_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status == sst_pkg::ST_FULL |-> !out_o.found)
    else $error("full rejection reported a present value");

  // a fresh result comes only out of the shift cycle
  a_rise_after_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a shift cycle");

endmodule

bind sorted_set_table sst_check u_sst_check (.*);
